/* hw/rtl/cc20_pkg.sv */
// Shared types, constants and the quarter-round function of the ChaCha20 stream cipher.
// Depends on nothing; every other file of the block imports it.
package cc20_pkg;

	localparam int DOUBLE_ROUNDS_DEF = 10;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	typedef logic [31:0] word_t;
	typedef logic [3:0][31:0] quad_t;

	localparam quad_t SIGMA = {32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0   = 3'd0,
		REG_KEY1   = 3'd1,
		REG_KEY2   = 3'd2,
		REG_KEY3   = 3'd3,
		REG_NONCE0 = 3'd4,
		REG_NONCE1 = 3'd5,
		REG_CTR    = 3'd6
	} cc20_reg_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADDBACK,
		ST_EMIT
	} cc20_state_t;

	typedef struct packed {
		logic in_rdy;
		logic take_in;
		logic start_block;
		logic round_en;
		logic diag;
		logic add_back;
		logic emit;
	} cc20_cmd_t;

	typedef struct packed {
		logic pos_zero;
		logic out_free;
	} cc20_stat_t;

	// Element 0 is a, 1 is b, 2 is c, 3 is d.
	function automatic quad_t quarter_round(quad_t x);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		quad_t r;
		a = x[0];
		b = x[1];
		c = x[2];
		d = x[3];
		a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
		c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
		a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
		c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
		r = {d, c, b, a};
		return r;
	endfunction

endpackage

/* hw/rtl/cc20_if.sv */
// Channel interfaces of the ChaCha20 stream cipher: message input, result output and
// register write. Depends on cc20_pkg for the register port widths.
interface cc20_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_in;
	logic [3:0]  byte_count;
	logic        last_chunk;

	modport source (output valid, data_in, byte_count, last_chunk, input ready);
	modport sink (input valid, data_in, byte_count, last_chunk, output ready);
endinterface

interface cc20_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_out;
	logic [3:0]  out_byte_count;
	logic        out_last;

	modport source (output valid, data_out, out_byte_count, out_last, input ready);
	modport sink (input valid, data_out, out_byte_count, out_last, output ready);
endinterface

interface cc20_cfg_if
	import cc20_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wr_data;

	modport source (output valid, reg_index, wr_data, input ready);
	modport sink (input valid, reg_index, wr_data, output ready);
endinterface

/* hw/rtl/chacha20_stream_cipher.sv */
// ChaCha20 stream cipher, eight message bytes per request, one result per request.
// A chunk inside a keystream block: result registered on acceptance, valid from the next cycle.
// A chunk opening a block: result after the rounds (one round per cycle in
// the shared round unit), then add-back, then the result stage; input is held off
// meanwhile. Reset clears position, block
// count, result valid and sets registers to their reset values; keystream is not cleared.
module chacha20_stream_cipher
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cc20_in_if.sink    din,
	cc20_out_if.source dout,
	cc20_cfg_if.sink   cfg
);

	cc20_cmd_t  cmd;
	cc20_stat_t stat;

	assign din.ready = cmd.in_rdy;
	assign cfg.ready = 1'b1;

	cc20_ctrl #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	cc20_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg.valid),
		.cfg_idx   (cfg.reg_index),
		.cfg_data  (cfg.wr_data),
		.in_data   (din.data_in),
		.in_count  (din.byte_count),
		.in_last   (din.last_chunk),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.out_data  (dout.data_out),
		.out_count (dout.out_byte_count),
		.out_last  (dout.out_last)
	);

endmodule

/* hw/rtl/cc20_ctrl.sv */
// Sequencer of the ChaCha20 stream cipher: accepts chunks, runs the round loop when a
// keystream block is due and schedules the result. Depends on cc20_pkg.
module cc20_ctrl
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = DOUBLE_ROUNDS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  cc20_stat_t stat,
	output cc20_cmd_t  cmd
);

	localparam int Rounds = 2 * DOUBLE_ROUNDS;
	localparam int RndW = $clog2(Rounds);

	cc20_state_t state_q;
	cc20_state_t state_d;
	logic [RndW-1:0] rnd_q;
	logic [RndW-1:0] rnd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rnd_d   = rnd_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_rdy  = stat.out_free;
				cmd.take_in = stat.out_free && in_valid;
				if (cmd.take_in) begin
					if (stat.pos_zero) begin
						cmd.start_block = 1'b1;
						rnd_d           = '0;
						state_d         = ST_ROUND;
					end else begin
						// Keystream for this position is already held, so the result is
						// produced straight away.
						cmd.emit = 1'b1;
					end
				end
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				cmd.diag     = rnd_q[0];
				if (rnd_q == RndW'(Rounds - 1)) begin
					rnd_d   = '0;
					state_d = ST_ADDBACK;
				end else begin
					rnd_d = rnd_q + 1'b1;
				end
			end
			ST_ADDBACK: begin
				cmd.add_back = 1'b1;
				state_d      = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == RndW'(Rounds - 1)) |=> state_q == ST_ADDBACK)
		else $error("round loop did not end after the final round");

	a_addback_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADDBACK |=> state_q == ST_EMIT)
		else $error("add-back not followed by result stage");

	a_round_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROUND |-> rnd_q <= RndW'(Rounds - 1))
		else $error("round counter beyond round count");

endmodule

/* hw/rtl/cc20_core.sv */
// Datapath of the ChaCha20 stream cipher: configuration registers, working state with one
// round per cycle, keystream store, chunk position and result register. Depends on cc20_pkg.
module cc20_core
	import cc20_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cc20_cmd_t             cmd,
	output cc20_stat_t            stat,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [63:0]           in_data,
	input  logic [3:0]            in_count,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [63:0]           out_data,
	output logic [3:0]            out_count,
	output logic                  out_last
);

	logic [3:0][63:0]  key_q;
	logic [63:0]       nonce0_q;
	logic [31:0]       nonce1_q;
	logic [31:0]       ctr_q;
	logic [15:0][31:0] work_q;
	logic [15:0][31:0] work_rnd;
	logic [15:0][31:0] init_w;
	logic [7:0][63:0]  ks_q;
	logic [2:0]        pos_q;
	logic [31:0]       blocks_q;
	logic [63:0]       hold_data_q;
	logic [3:0]        hold_cnt_q;
	logic              hold_last_q;
	logic              out_valid_q;
	logic [63:0]       out_data_q;
	logic [3:0]        out_cnt_q;
	logic              out_last_q;
	logic [3:0]        in_cnt_sat;
	logic [63:0]       src_data;
	logic [3:0]        src_cnt;
	logic              src_last;
	logic [63:0]       byte_mask;
	logic [63:0]       res_data;
	quad_t [3:0]       q_in;
	quad_t [3:0]       q_out;
	logic [3:0][3:0]   ia;
	logic [3:0][3:0]   ib;
	logic [3:0][3:0]   ic;
	logic [3:0][3:0]   id;

	// Block input words; the counter word is the message's starting counter plus the
	// number of blocks already used, wrapping.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = SIGMA[i];
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = ctr_q + blocks_q;
		init_w[13] = nonce0_q[31:0];
		init_w[14] = nonce0_q[63:32];
		init_w[15] = nonce1_q;
	end

	// Four quarter-rounds in parallel, on columns or on diagonals.
	always_comb begin
		work_rnd = work_q;
		for (int i = 0; i < 4; i++) begin
			ia[i] = {2'b00, 2'(i)};
			ib[i] = {2'b01, 2'(i) + {1'b0, cmd.diag}};
			ic[i] = {2'b10, 2'(i) + {cmd.diag, 1'b0}};
			id[i] = {2'b11, 2'(i) + {cmd.diag, cmd.diag}};
			q_in[i]  = {work_q[id[i]], work_q[ic[i]], work_q[ib[i]], work_q[ia[i]]};
			q_out[i] = quarter_round(q_in[i]);
		end
		for (int i = 0; i < 4; i++) begin
			work_rnd[ia[i]] = q_out[i][0];
			work_rnd[ib[i]] = q_out[i][1];
			work_rnd[ic[i]] = q_out[i][2];
			work_rnd[id[i]] = q_out[i][3];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_block) begin
			work_q <= init_w;
		end else if (cmd.round_en) begin
			work_q <= work_rnd;
		end
		if (cmd.add_back) begin
			for (int j = 0; j < 8; j++) begin
				ks_q[j] <= {work_q[2 * j + 1] + init_w[2 * j + 1], work_q[2 * j] + init_w[2 * j]};
			end
		end
		if (cmd.take_in) begin
			hold_data_q <= in_data;
			hold_cnt_q  <= in_cnt_sat;
			hold_last_q <= in_last;
		end
		if (cmd.emit) begin
			out_data_q <= res_data;
			out_cnt_q  <= src_cnt;
			out_last_q <= src_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			nonce0_q <= '0;
			nonce1_q <= '0;
			ctr_q    <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY0:   key_q[0] <= cfg_data;
				REG_KEY1:   key_q[1] <= cfg_data;
				REG_KEY2:   key_q[2] <= cfg_data;
				REG_KEY3:   key_q[3] <= cfg_data;
				REG_NONCE0: nonce0_q <= cfg_data;
				REG_NONCE1: nonce1_q <= cfg_data[31:0];
				REG_CTR:    ctr_q    <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign in_cnt_sat = (in_count > 4'd8) ? 4'd8 : in_count;
	assign src_data   = cmd.take_in ? in_data : hold_data_q;
	assign src_cnt    = cmd.take_in ? in_cnt_sat : hold_cnt_q;
	assign src_last   = cmd.take_in ? in_last : hold_last_q;

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			byte_mask[8 * j +: 8] = (4'(j) < src_cnt) ? 8'hFF : 8'h00;
		end
	end

	assign res_data = (src_data ^ ks_q[pos_q]) & byte_mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			blocks_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.emit) begin
				if (src_last) begin
					pos_q    <= '0;
					blocks_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
					if (pos_q == 3'd7) begin
						blocks_q <= blocks_q + 1'b1;
					end
				end
			end
		end
	end

	assign stat.pos_zero = (pos_q == 3'd0);
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign out_data      = out_data_q;
	assign out_count     = out_cnt_q;
	assign out_last      = out_last_q;

	a_block_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_block |-> pos_q == 3'd0)
		else $error("keystream block started away from a block boundary");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result written over one not yet taken");

	a_emit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && !src_last) |=> pos_q == $past(pos_q) + 3'd1)
		else $error("chunk position did not advance");

endmodule

/* bench/chacha20_stream_cipher_tb.sv */
// Self-checking bench for chacha20_stream_cipher: a directed table of requests, then random
// messages and register settings, checked against an in-bench ChaCha20 keystream predictor.
// Depends on cc20_pkg, the cc20 channel interfaces and the chacha20_stream_cipher RTL.
module chacha20_stream_cipher_tb;
	import cc20_pkg::*;

	localparam int DR = DOUBLE_ROUNDS_DEF;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
	} chunk_t;

	typedef enum {ROW_ITEM, ROW_REG} row_kind_e;

	typedef struct {
		row_kind_e   kind;
		cc20_reg_e   sel;
		logic [63:0] value;
		logic [3:0]  count;
		logic        last;
		bit          typed;
		chunk_t      gold;
	} stim_row_t;

	logic clk;
	logic arst_n;

	cc20_in_if  din_if();
	cc20_out_if dout_if();
	cc20_cfg_if cfg_if();

	chacha20_stream_cipher #(.DOUBLE_ROUNDS(DR)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.din(din_if),
		.dout(dout_if),
		.cfg(cfg_if)
	);

	// Predictor copy of the registers and of the keystream state.
	logic [63:0] key_w [4];
	logic [63:0] nonce_lo;
	logic [31:0] nonce_hi;
	logic [31:0] ctr_base;
	logic [31:0] ks_words [16];
	logic [2:0]  chunk_pos;
	logic [31:0] blocks_used;

	chunk_t    expected_chunks [$];
	stim_row_t stim_table [$];
	int        mismatch_count;
	int        stall_cycles;
	int        tx_idle_pct;
	int        rx_stall_pct;
	int        msg_left;
	bit        cfg_open;
	logic      rx_hold;
	logic      tx_typed;
	chunk_t    tx_gold;
	event      rx_hold_go;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] rotl32(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [127:0] qround(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		a = a + b; d = rotl32(d ^ a, 16);
		c = c + d; b = rotl32(b ^ c, 12);
		a = a + b; d = rotl32(d ^ a, 8);
		c = c + d; b = rotl32(b ^ c, 7);
		return {d, c, b, a};
	endfunction

	function automatic void refill_keystream(logic [31:0] blk_ctr);
		logic [31:0] init_w [16];
		logic [31:0] mix_w [16];
		int i;
		int r;
		int a;
		int b;
		int c;
		int d;
		// The "expand 32-byte k" words.
		init_w[0] = 32'h61707865;
		init_w[1] = 32'h3320646e;
		init_w[2] = 32'h79622d32;
		init_w[3] = 32'h6b206574;
		for (i = 0; i < 4; i++) begin
			init_w[4 + 2 * i] = key_w[i][31:0];
			init_w[5 + 2 * i] = key_w[i][63:32];
		end
		init_w[12] = blk_ctr;
		init_w[13] = nonce_lo[31:0];
		init_w[14] = nonce_lo[63:32];
		init_w[15] = nonce_hi;
		mix_w = init_w;
		// Even rounds work on columns, odd rounds on diagonals.
		for (r = 0; r < 2 * DR; r++) begin
			for (i = 0; i < 4; i++) begin
				a = i;
				if (r % 2 == 0) begin
					b = 4 + i;
					c = 8 + i;
					d = 12 + i;
				end else begin
					b = 4 + (i + 1) % 4;
					c = 8 + (i + 2) % 4;
					d = 12 + (i + 3) % 4;
				end
				{mix_w[d], mix_w[c], mix_w[b], mix_w[a]} =
					qround(mix_w[a], mix_w[b], mix_w[c], mix_w[d]);
			end
		end
		for (i = 0; i < 16; i++)
			ks_words[i] = mix_w[i] + init_w[i];
	endfunction

	function automatic chunk_t predict_chunk(logic [63:0] data, logic [3:0] cnt, logic lst);
		int n;
		logic [63:0] ks;
		logic [63:0] mask;
		chunk_t res;
		n = (cnt > 4'd8) ? 8 : int'(cnt);
		if (chunk_pos == 3'd0)
			refill_keystream(ctr_base + blocks_used);
		ks = {ks_words[2 * chunk_pos + 1], ks_words[2 * chunk_pos]};
		mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
		res.data = (data ^ ks) & mask;
		res.count = n[3:0];
		res.last = lst;
		// A short chunk still uses up a whole eight-byte slot of the keystream.
		chunk_pos = chunk_pos + 3'd1;
		if (chunk_pos == 3'd0)
			blocks_used = blocks_used + 32'd1;
		if (lst) begin
			chunk_pos = 3'd0;
			blocks_used = 32'd0;
		end
		return res;
	endfunction

	// Prediction happens when a request is accepted; results are checked when they are taken.
	always @(posedge clk) begin
		chunk_t got;
		chunk_t want;
		if (arst_n) begin
			if ((cfg_if.valid && cfg_if.ready) || (din_if.valid && din_if.ready) ||
					(dout_if.valid && dout_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cc20_reg_e'(cfg_if.reg_index))
					REG_KEY0:   key_w[0] = cfg_if.wr_data;
					REG_KEY1:   key_w[1] = cfg_if.wr_data;
					REG_KEY2:   key_w[2] = cfg_if.wr_data;
					REG_KEY3:   key_w[3] = cfg_if.wr_data;
					REG_NONCE0: nonce_lo = cfg_if.wr_data;
					REG_NONCE1: nonce_hi = cfg_if.wr_data[31:0];
					REG_CTR:    ctr_base = cfg_if.wr_data[31:0];
					default: ;
				endcase
			end
			if (din_if.valid && din_if.ready) begin
				want = predict_chunk(din_if.data_in, din_if.byte_count, din_if.last_chunk);
				expected_chunks.insert(expected_chunks.size(), tx_typed ? tx_gold : want);
			end
			if (dout_if.valid && dout_if.ready) begin
				got = {dout_if.data_out, dout_if.out_byte_count, dout_if.out_last};
				if (expected_chunks.size() == 0) begin
					$error("unexpected result: data_out %h out_byte_count %0d out_last %0d",
						got.data, got.count, got.last);
					mismatch_count++;
				end else begin
					want = expected_chunks.pop_front();
					if (got.data !== want.data) begin
						$error("data_out: expected %h, got %h", want.data, got.data);
						mismatch_count++;
					end
					if (got.count !== want.count) begin
						$error("out_byte_count: expected %0d, got %0d", want.count, got.count);
						mismatch_count++;
					end
					if (got.last !== want.last) begin
						$error("out_last: expected %0d, got %0d", want.last, got.last);
						mismatch_count++;
					end
				end
			end
		end
	end

	always @(posedge clk)
		dout_if.ready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

	// Long hold-off of the result channel, so that the block fills and stalls its input.
	initial begin
		rx_hold = 1'b0;
		forever begin
			@(rx_hold_go);
			rx_hold <= 1'b1;
			repeat (RX_HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	task automatic wait_drained();
		din_if.valid <= 1'b0;
		do
			@(negedge clk);
		while (expected_chunks.size() != 0);
		@(posedge clk);
	endtask

	task automatic close_cfg();
		if (cfg_open) begin
			cfg_if.valid <= 1'b0;
			cfg_open = 1'b0;
		end
	endtask

	task automatic write_reg(input cc20_reg_e sel, input logic [63:0] v);
		if (!cfg_open)
			wait_drained();
		cfg_if.valid <= 1'b1;
		cfg_if.reg_index <= sel;
		cfg_if.wr_data <= v;
		cfg_open = 1'b1;
		do
			@(posedge clk);
		while (!cfg_if.ready);
	endtask

	task automatic offer_chunk(input logic [63:0] d, input logic [3:0] n, input logic lst,
			input bit typed, input chunk_t gold);
		close_cfg();
		while ($urandom_range(99) < tx_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.data_in <= d;
		din_if.byte_count <= n;
		din_if.last_chunk <= lst;
		tx_typed <= typed;
		tx_gold <= gold;
		do
			@(posedge clk);
		while (!din_if.ready);
	endtask

	task automatic add_item(input logic [63:0] d, input logic [3:0] n, input logic lst,
			input bit typed, input chunk_t gold);
		stim_row_t row;
		row = '{ROW_ITEM, REG_KEY0, d, n, lst, typed, gold};
		stim_table.insert(stim_table.size(), row);
	endtask

	task automatic add_reg(input cc20_reg_e sel, input logic [63:0] v);
		stim_row_t row;
		row = '{ROW_REG, sel, v, 4'd0, 1'b0, 1'b0, chunk_t'(0)};
		stim_table.insert(stim_table.size(), row);
	endtask

	// Random messages; a phase may stop mid-message, so the next settings land mid-block.
	task automatic run_phase(input int tx_pct, input int rx_pct, input int items);
		logic [63:0] d;
		logic [3:0]  n;
		logic        lst;
		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		repeat (items) begin
			if (msg_left == 0)
				msg_left = ($urandom_range(4) == 0) ? $urandom_range(48, 25) :
					$urandom_range(24, 1);
			lst = (msg_left == 1);
			msg_left--;
			if (lst)
				n = 4'(($urandom_range(9) < 7) ? $urandom_range(8, 1) :
					$urandom_range(15, 0));
			else
				n = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 0)) : 4'd8;
			case ($urandom_range(19))
				0: d = '0;
				1: d = '1;
				default: d = {$urandom, $urandom};
			endcase
			offer_chunk(d, n, lst, 1'b0, chunk_t'(0));
		end
	endtask

	task automatic reprogram();
		cc20_reg_e   sel;
		logic [63:0] v;
		sel = sel.first();
		repeat (sel.num()) begin
			if ($urandom_range(9) < 6) begin
				case ($urandom_range(3))
					0: v = '0;
					1: v = '1;
					default: v = {$urandom, $urandom};
				endcase
				// Counters close to the top make the block counter wrap within a message.
				if (sel == REG_CTR && $urandom_range(2) == 0)
					v = 64'hFFFF_FFFF - $urandom_range(2);
				write_reg(sel, v);
			end
			sel = sel.next();
		end
		close_cfg();
	endtask

	initial begin
		cc20_reg_e sel;
		int i;
		arst_n = 1'b0;
		din_if.valid = 1'b0;
		din_if.data_in = '0;
		din_if.byte_count = '0;
		din_if.last_chunk = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.reg_index = '0;
		cfg_if.wr_data = '0;
		tx_typed = 1'b0;
		tx_gold = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		msg_left = 0;
		cfg_open = 1'b0;
		mismatch_count = 0;
		stall_cycles = 0;
		for (i = 0; i < 4; i++)
			key_w[i] = '0;
		nonce_lo = '0;
		nonce_hi = '0;
		ctr_base = 32'd1;
		for (i = 0; i < 16; i++)
			ks_words[i] = '0;
		chunk_pos = '0;
		blocks_used = '0;

		// Reset settings: zero key and nonce, counter one. A zero count gives an empty result.
		add_item(64'h0, 4'd8, 1'b0, 1'b0, chunk_t'(0));
		add_item('1, 4'd8, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'h0123_4567_89ab_cdef, 4'd0, 1'b0, 1'b1, chunk_t'{64'h0, 4'd0, 1'b0});
		add_item(64'hfedc_ba98_7654_3210, 4'd15, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'ha5a5_a5a5_a5a5_a5a5, 4'd9, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'h5a5a_5a5a_5a5a_5a5a, 4'd3, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'h0, 4'd8, 1'b0, 1'b0, chunk_t'(0));
		add_item('1, 4'd8, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'h1122_3344_5566_7788, 4'd1, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'h99aa_bbcc_ddee_ff00, 4'd7, 1'b1, 1'b0, chunk_t'(0));
		add_item(64'hdead_beef_cafe_f00d, 4'd0, 1'b1, 1'b1, chunk_t'{64'h0, 4'd0, 1'b1});
		// Every register at its top value; the ninth chunk runs on a wrapped counter.
		sel = sel.first();
		repeat (sel.num()) begin
			add_reg(sel, '1);
			sel = sel.next();
		end
		for (i = 0; i < 9; i++)
			add_item((i % 2 == 0) ? 64'h0 : '1, 4'd8, i == 8, 1'b0, chunk_t'(0));
		sel = sel.first();
		repeat (sel.num()) begin
			add_reg(sel, '0);
			sel = sel.next();
		end
		add_item('1, 4'd8, 1'b1, 1'b0, chunk_t'(0));
		add_item(64'h0, 4'd8, 1'b0, 1'b0, chunk_t'(0));
		add_item(64'h0f0f_0f0f_f0f0_f0f0, 4'd4, 1'b1, 1'b0, chunk_t'(0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[k]) begin
			if (stim_table[k].kind == ROW_REG)
				write_reg(stim_table[k].sel, stim_table[k].value);
			else
				offer_chunk(stim_table[k].value, stim_table[k].count, stim_table[k].last,
					stim_table[k].typed, stim_table[k].gold);
		end
		close_cfg();

		run_phase(0, 0, 70);
		reprogram();
		run_phase(86, 0, 70);
		reprogram();
		run_phase(0, 86, 70);
		reprogram();
		-> rx_hold_go;
		run_phase(0, 0, 40);
		// The sender holds back here until every result is home.
		wait_drained();
		reprogram();
		run_phase(29, 29, 70);
		reprogram();
		run_phase(0, 0, 60);

		close_cfg();
		wait_drained();
		repeat (2 * DR + 10) @(posedge clk);
		@(negedge clk);
		if (mismatch_count == 0 && expected_chunks.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
